// ----- rtl/core/kdn_pkg.sv -----
// Shared types and constants for the kd-tree nearest-point search block.
// No dependencies; imported by every module under rtl/core.
package kdn_pkg;

   localparam int MAX_POINTS_DEF = 4096;
   localparam int COORD_BITS_DEF = 16;

   // Fixed stream field widths
   localparam int INDEX_FIELD_BITS = 12;
   localparam int COORD_FIELD_BITS = 16;
   localparam int COUNT_FIELD_BITS = 13;
   localparam int DIST_FIELD_BITS  = 34;

   // req_tdata layout, lowest bit first: point_index, coord_x, coord_y, coord_z
   localparam int REQ_INDEX_LSB   = 0;
   localparam int REQ_X_LSB       = REQ_INDEX_LSB + INDEX_FIELD_BITS;
   localparam int REQ_Y_LSB       = REQ_X_LSB + COORD_FIELD_BITS;
   localparam int REQ_Z_LSB       = REQ_Y_LSB + COORD_FIELD_BITS;
   localparam int REQ_USED_BITS   = REQ_Z_LSB + COORD_FIELD_BITS;
   localparam int REQ_TDATA_BITS  = ((REQ_USED_BITS + 7) / 8) * 8;

   // rsp_tdata layout, lowest bit first: nearest_index, nearest_dist_sq
   localparam int RSP_USED_BITS   = INDEX_FIELD_BITS + DIST_FIELD_BITS;
   localparam int RSP_TDATA_BITS  = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS    = RSP_TDATA_BITS - RSP_USED_BITS;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_QUERY = 1'b1
   } kdn_kind_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } kdn_axis_type;

   typedef struct packed {
      logic         start;
      kdn_axis_type axis;
   } kdn_dist_cmd_type;

endpackage

// ----- rtl/core/kdn_point_mem.sv -----
// Point store: single write port, single registered read port.
// Depends on kdn_pkg.
module kdn_point_mem
   import kdn_pkg::*;
#(
   parameter int DEPTH     = MAX_POINTS_DEF,
   parameter int DATA_BITS = 3 * COORD_BITS_DEF,
   localparam int AW       = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/kdn_dist_unit.sv -----
// Shared squarer and accumulator: one axis per cycle, squared distance over 3 axes,
// plus the square along one chosen axis. Depends on kdn_pkg.
module kdn_dist_unit
   import kdn_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int SQW       = 2 * COORD_BITS,
   localparam int DW        = SQW + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kdn_dist_cmd_type          cmd,
   input  logic [3*COORD_BITS-1:0]   point,
   input  logic [3*COORD_BITS-1:0]   query,
   output logic                      done,
   output logic [DW-1:0]             sum,
   output logic [SQW-1:0]            plane
);

   logic                   active_ff;
   logic [1:0]             phase_ff;
   kdn_axis_type           axis_ff;
   logic                   done_ff;
   logic [SQW-1:0]         sq_ff;
   logic [DW-1:0]          acc_ff;
   logic [SQW-1:0]         plane_ff;

   logic signed [COORD_BITS-1:0]   p_sel;
   logic signed [COORD_BITS-1:0]   q_sel;
   logic signed [COORD_BITS:0]     diff;
   logic signed [2*COORD_BITS+1:0] prod;
   logic [SQW-1:0]                 sq_in;

   always_comb begin
      unique case (phase_ff)
         2'd0: begin
            p_sel = point[0 +: COORD_BITS];
            q_sel = query[0 +: COORD_BITS];
         end
         2'd1: begin
            p_sel = point[COORD_BITS +: COORD_BITS];
            q_sel = query[COORD_BITS +: COORD_BITS];
         end
         default: begin
            p_sel = point[2*COORD_BITS +: COORD_BITS];
            q_sel = query[2*COORD_BITS +: COORD_BITS];
         end
      endcase
      diff  = (COORD_BITS+1)'(q_sel) - (COORD_BITS+1)'(p_sel);
      prod  = (2*COORD_BITS+2)'(diff) * (2*COORD_BITS+2)'(diff);
      sq_in = prod[SQW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         phase_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            active_ff <= 1'b1;
            phase_ff  <= 2'd0;
            axis_ff   <= cmd.axis;
         end else if (active_ff) begin
            phase_ff <= phase_ff + 2'd1;
            sq_ff    <= sq_in;
            // sq_ff holds the registered square of the previous axis
            if (phase_ff == 2'd0) begin
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_ff + DW'(sq_ff);
            end
            if (phase_ff != 2'd0 && (phase_ff - 2'd1) == 2'(axis_ff)) begin
               plane_ff <= sq_ff;
            end
            if (phase_ff == 2'd3) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign done  = done_ff;
   assign sum   = acc_ff;
   assign plane = plane_ff;

endmodule

// ----- rtl/core/kdn_search_ctrl.sv -----
// Search sequencer: walks the implicit kd-tree depth first with an explicit frame stack,
// driving the point store read port and the shared distance unit. Depends on kdn_pkg.
module kdn_search_ctrl
   import kdn_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int AW        = $clog2(MAX_POINTS),
   localparam int CW        = $clog2(MAX_POINTS + 1),
   localparam int PW        = 3 * COORD_BITS,
   localparam int SQW       = 2 * COORD_BITS,
   localparam int DW        = SQW + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kdn_kind_type      req_kind,
   input  logic [PW-1:0]     req_point,
   input  logic [CW-1:0]     point_count,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  logic [PW-1:0]     rd_data,
   output kdn_dist_cmd_type  dist_cmd,
   output logic [PW-1:0]     dist_query,
   input  logic              dist_done,
   input  logic [DW-1:0]     dist_sum,
   input  logic [SQW-1:0]    dist_plane,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [AW-1:0]     rsp_index,
   output logic [DW-1:0]     rsp_dist
);

   localparam int SD  = AW + 1;
   localparam int SDW = $clog2(SD + 1);
   localparam int SIW = $clog2(SD);

   typedef struct packed {
      logic [CW-1:0] lo;
      logic [CW-1:0] hi;
      logic          go_low;
      logic          far_side;
      logic [AW-1:0] best;
      logic [DW-1:0] best_d;
   } frame_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENTER,
      S_DESC,
      S_LEAF_RD,
      S_LEAF_WAIT,
      S_RET,
      S_NODE_RD,
      S_NODE_WAIT,
      S_NODE_PRUNE
   } state_type;

   state_type           state_ff;
   logic [SDW-1:0]      depth_ff;
   kdn_axis_type        axis_ff;
   logic [PW-1:0]       query_ff;
   logic [CW-1:0]       lo_ff;
   logic [CW-1:0]       hi_ff;
   logic                go_low_ff;
   logic [AW-1:0]       best_ff;
   logic [DW-1:0]       best_d_ff;
   logic [AW-1:0]       ret_idx_ff;
   logic [DW-1:0]       ret_d_ff;
   logic                rsp_valid_ff;
   logic [AW-1:0]       rsp_index_ff;
   logic [DW-1:0]       rsp_dist_ff;
   frame_type           stack_ff [SD];

   logic [CW-1:0]       cur_mid;
   logic [CW-1:0]       cur_mid_inc;
   logic                cur_leaf;
   logic [AW-1:0]       leaf_idx;
   frame_type           top_frame;
   logic [CW-1:0]       pop_mid;
   logic [SIW-1:0]      push_idx;
   logic [SIW-1:0]      pop_idx;
   logic                go_low_in;
   logic signed [COORD_BITS-1:0] node_c;
   logic signed [COORD_BITS-1:0] query_c;

   function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
      logic [CW-1:0] span;
      span = hi - lo;
      return lo + (span >> 1);
   endfunction

   function automatic logic [COORD_BITS-1:0] coord_of(input logic [PW-1:0] vec,
                                                      input kdn_axis_type axis);
      logic [COORD_BITS-1:0] c;
      unique case (axis)
         AXIS_X:  c = vec[0 +: COORD_BITS];
         AXIS_Y:  c = vec[COORD_BITS +: COORD_BITS];
         AXIS_Z:  c = vec[2*COORD_BITS +: COORD_BITS];
         default: c = vec[0 +: COORD_BITS];
      endcase
      return c;
   endfunction

   function automatic kdn_axis_type axis_next(input kdn_axis_type axis);
      kdn_axis_type n;
      unique case (axis)
         AXIS_X:  n = AXIS_Y;
         AXIS_Y:  n = AXIS_Z;
         default: n = AXIS_X;
      endcase
      return n;
   endfunction

   function automatic kdn_axis_type axis_prev(input kdn_axis_type axis);
      kdn_axis_type n;
      unique case (axis)
         AXIS_Y:  n = AXIS_X;
         AXIS_Z:  n = AXIS_Y;
         default: n = AXIS_Z;
      endcase
      return n;
   endfunction

   always_comb begin
      cur_mid     = mid_of(lo_ff, hi_ff);
      cur_mid_inc = cur_mid + CW'(1);
      cur_leaf    = ({1'b0, lo_ff} + (CW+1)'(1)) >= {1'b0, hi_ff};
      leaf_idx    = (lo_ff >= point_count) ? AW'(point_count - CW'(1)) : AW'(lo_ff);
      push_idx    = depth_ff[SIW-1:0];
      pop_idx     = SIW'(depth_ff - SDW'(1));
      top_frame   = stack_ff[pop_idx];
      pop_mid     = mid_of(top_frame.lo, top_frame.hi);
      node_c      = coord_of(rd_data, axis_ff);
      query_c     = coord_of(query_ff, axis_ff);
      go_low_in   = node_c > query_c;
   end

   // store read port
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = AW'(cur_mid);
      unique case (state_ff)
         S_ENTER: begin
            rd_en   = 1'b1;
            rd_addr = cur_leaf ? leaf_idx : AW'(cur_mid);
         end
         S_RET: begin
            rd_en   = (depth_ff != '0) && !top_frame.far_side;
            rd_addr = AW'(pop_mid);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      dist_cmd.start = (state_ff == S_LEAF_RD) || (state_ff == S_NODE_RD);
      dist_cmd.axis  = axis_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_kind == KIND_QUERY) begin
                  query_ff <= req_point;
                  lo_ff    <= '0;
                  hi_ff    <= point_count;
                  depth_ff <= '0;
                  axis_ff  <= AXIS_X;
                  state_ff <= S_ENTER;
               end
            end
            S_ENTER: begin
               if (cur_leaf) begin
                  ret_idx_ff <= leaf_idx;
                  state_ff   <= S_LEAF_RD;
               end else begin
                  state_ff <= S_DESC;
               end
            end
            S_DESC: begin
               // descend into the side that holds the query first
               stack_ff[push_idx] <= '{lo: lo_ff, hi: hi_ff, go_low: go_low_in,
                                       far_side: 1'b0, best: best_ff, best_d: best_d_ff};
               if (go_low_in) begin
                  hi_ff <= cur_mid;
               end else begin
                  lo_ff <= cur_mid_inc;
               end
               depth_ff <= depth_ff + SDW'(1);
               axis_ff  <= axis_next(axis_ff);
               state_ff <= S_ENTER;
            end
            S_LEAF_RD: begin
               state_ff <= S_LEAF_WAIT;
            end
            S_LEAF_WAIT: begin
               if (dist_done) begin
                  ret_d_ff <= dist_sum;
                  state_ff <= S_RET;
               end
            end
            S_RET: begin
               if (depth_ff == '0) begin
                  // hold the final answer until the output register frees up
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_index_ff <= ret_idx_ff;
                     rsp_dist_ff  <= ret_d_ff;
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  depth_ff <= depth_ff - SDW'(1);
                  axis_ff  <= axis_prev(axis_ff);
                  if (!top_frame.far_side) begin
                     lo_ff     <= top_frame.lo;
                     hi_ff     <= top_frame.hi;
                     go_low_ff <= top_frame.go_low;
                     best_ff   <= ret_idx_ff;
                     best_d_ff <= ret_d_ff;
                     state_ff  <= S_NODE_RD;
                  end else if (ret_d_ff > top_frame.best_d) begin
                     ret_idx_ff <= top_frame.best;
                     ret_d_ff   <= top_frame.best_d;
                  end
               end
            end
            S_NODE_RD: begin
               state_ff <= S_NODE_WAIT;
            end
            S_NODE_WAIT: begin
               if (dist_done) begin
                  if (dist_sum < best_d_ff) begin
                     best_ff   <= AW'(cur_mid);
                     best_d_ff <= dist_sum;
                  end
                  state_ff <= S_NODE_PRUNE;
               end
            end
            S_NODE_PRUNE: begin
               if (DW'(dist_plane) > best_d_ff) begin
                  ret_idx_ff <= best_ff;
                  ret_d_ff   <= best_d_ff;
                  state_ff   <= S_RET;
               end else begin
                  stack_ff[push_idx] <= '{lo: lo_ff, hi: hi_ff, go_low: go_low_ff,
                                          far_side: 1'b1, best: best_ff, best_d: best_d_ff};
                  if (go_low_ff) begin
                     lo_ff <= cur_mid_inc;
                  end else begin
                     hi_ff <= cur_mid;
                  end
                  depth_ff <= depth_ff + SDW'(1);
                  axis_ff  <= axis_next(axis_ff);
                  state_ff <= S_ENTER;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign dist_query = query_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_dist   = rsp_dist_ff;

endmodule

// ----- rtl/core/kd_tree_nearest_search.sv -----
// Nearest-point search over a 3-D kd-tree stored in implicit (median-at-midpoint) layout.
// Requests arrive on req_* (tuser = kind): a write stores one point into slot point_index,
// a query runs a depth-first search over slots [0, point_count) and returns one response
// on rsp_* carrying the nearest slot and its exact squared distance. Writes give no response.
// point_count is set through csr_wr_en / csr_wr_data; the user must set it only while the
// block is idle, which the block itself does not enforce. It resets to 1, and values outside
// [1, MAX_POINTS] are clamped. A query walks the tree with one shared squarer, one axis per
// cycle: each internal node visited takes entry, node read, re-read and 3-axis distance on
// return, and a prune test; the node count depends on pruning, roughly 2*log2(point_count)
// nodes for a well-placed query. The store read port and the squarer set the query time.
// req_tready stays low for the whole query.
// Reset clears the sequencer and the response valid and returns point_count to 1; the point
// store is not cleared and slots must be written before a query reaches them.
// When the receiver stalls, the response holds in the output register; the block still takes
// writes and starts the next query, which waits at its end until the register frees up.
// Depends on kdn_pkg, kdn_point_mem, kdn_dist_unit and kdn_search_ctrl.
module kd_tree_nearest_search
   import kdn_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // point_index[11:0], coord_x[27:12], coord_y[43:28], coord_z[59:44], zero pad
   input  logic [REQ_TDATA_BITS-1:0]   req_tdata,
   // kind[0]
   input  logic [0:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // nearest_index[11:0], nearest_dist_sq[45:12], zero pad
   output logic [RSP_TDATA_BITS-1:0]   rsp_tdata,
   input  logic                        csr_wr_en,
   input  logic [COUNT_FIELD_BITS-1:0] csr_wr_data
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int PW   = 3 * COORD_BITS;
   localparam int SQW  = 2 * COORD_BITS;
   localparam int DW   = SQW + 2;
   localparam int CMPW = (CW > COUNT_FIELD_BITS) ? CW : COUNT_FIELD_BITS;
   localparam int SLW  = (AW + 1 > INDEX_FIELD_BITS) ? AW + 1 : INDEX_FIELD_BITS;

   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               count_in;

   kdn_kind_type                req_kind;
   logic [INDEX_FIELD_BITS-1:0] req_slot;
   logic [PW-1:0]               req_point;
   logic                        req_accept;
   logic                        wr_en;

   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [PW-1:0]               rd_data;
   kdn_dist_cmd_type            dist_cmd;
   logic [PW-1:0]               dist_query;
   logic                        dist_done;
   logic [DW-1:0]               dist_sum;
   logic [SQW-1:0]              dist_plane;
   logic [AW-1:0]               rsp_index;
   logic [DW-1:0]               rsp_dist;

   // clamp the point count into [1, MAX_POINTS]
   always_comb begin
      priority if (csr_wr_data == '0) begin
         count_in = CW'(1);
      end else if (CMPW'(csr_wr_data) > CMPW'(MAX_POINTS)) begin
         count_in = CW'(MAX_POINTS);
      end else begin
         count_in = CW'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(1);
      end else if (csr_wr_en) begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      req_kind   = kdn_kind_type'(req_tuser[0]);
      req_slot   = req_tdata[REQ_INDEX_LSB +: INDEX_FIELD_BITS];
      req_point  = {COORD_BITS'(req_tdata[REQ_Z_LSB +: COORD_FIELD_BITS]),
                    COORD_BITS'(req_tdata[REQ_Y_LSB +: COORD_FIELD_BITS]),
                    COORD_BITS'(req_tdata[REQ_X_LSB +: COORD_FIELD_BITS])};
      req_accept = req_tvalid && req_tready;
      // drop writes to slots beyond the store
      wr_en      = req_accept && (req_kind == KIND_WRITE)
                   && (SLW'(req_slot) < SLW'(MAX_POINTS));
   end

   kdn_point_mem #(
      .DEPTH     (MAX_POINTS),
      .DATA_BITS (PW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_slot)),
      .wr_data (req_point),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kdn_dist_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock (clock),
      .reset (reset),
      .cmd   (dist_cmd),
      .point (rd_data),
      .query (dist_query),
      .done  (dist_done),
      .sum   (dist_sum),
      .plane (dist_plane)
   );

   kdn_search_ctrl #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_kind),
      .req_point   (req_point),
      .point_count (count_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .dist_cmd    (dist_cmd),
      .dist_query  (dist_query),
      .dist_done   (dist_done),
      .dist_sum    (dist_sum),
      .dist_plane  (dist_plane),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_index   (rsp_index),
      .rsp_dist    (rsp_dist)
   );

   assign rsp_tdata = {RSP_PAD_BITS'(0), DIST_FIELD_BITS'(rsp_dist),
                       INDEX_FIELD_BITS'(rsp_index)};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CW'(MAX_POINTS))
      else $error("point count left its clamped range");

   a_result_in_tree: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> CW'(rsp_index) < count_ff)
      else $error("nearest index outside the stored tree");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind == KIND_QUERY |=> !req_tready)
      else $error("query accepted without the search starting");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind == KIND_WRITE && !rsp_tvalid |=> !rsp_tvalid)
      else $error("point write produced a response");

endmodule
